// ===== rtl/skf_pkg.sv =====
`default_nettype none

package skf_pkg;

    localparam int AXES_DEF     = 3;
    localparam int EST_FRAC_DEF = 16;

    localparam int ANGLE_W   = 16;
    localparam int RATE_W    = 17;
    localparam int ERR_W     = 32;
    localparam int NOISE_W   = 16;
    localparam int GAIN_W    = 17;
    localparam int GAIN_FRAC = 16;

    localparam logic [GAIN_W-1:0]  GAIN_ONE     = 17'h10000;
    localparam logic [ERR_W-1:0]   MEAS_ERR_RST = 32'd65536;
    localparam logic [NOISE_W-1:0] NOISE_RST    = 16'd6554;
    localparam logic               ENABLE_RST   = 1'b1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_ERR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd2;

    typedef enum logic {
        MDU_MUL,
        MDU_DIV
    } t_mdu_op;

    typedef struct packed {
        logic    go;
        t_mdu_op op;
    } t_mdu_req;

    typedef struct packed {
        logic done;
    } t_mdu_rsp;

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/skf_mdu.sv =====
`default_nettype none

// Shared shift-add unit: one adder, one quotient or multiplier bit per cycle.
module skf_mdu #(
    parameter int WA = 33
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire skf_pkg::t_mdu_req               i_req,
    input  wire logic [WA-1:0]                   i_a,
    input  wire logic [skf_pkg::GAIN_W-1:0]      i_b,
    input  wire logic [skf_pkg::ERR_W-1:0]       i_n,
    output skf_pkg::t_mdu_rsp                    o_rsp,
    output logic [WA+skf_pkg::GAIN_W-1:0]        o_acc,
    output logic [skf_pkg::GAIN_W-1:0]           o_quot
);

    localparam int WP    = WA + skf_pkg::GAIN_W;
    localparam int CNT_W = $clog2(skf_pkg::GAIN_W + 1);

    logic [WP-1:0]               r_acc;
    logic [WA-1:0]               r_a;
    logic [skf_pkg::GAIN_W-1:0]  r_b;
    logic [CNT_W-1:0]            r_cnt;
    skf_pkg::t_mdu_op            r_op;
    logic                        r_first;
    logic                        r_done;

    logic [WP-1:0] add_x;
    logic [WP-1:0] add_y;
    logic          add_cin;
    logic [WP:0]   add_sum;
    logic          ge;

    // Divide: trial subtract of the divisor. Multiply: add the multiplicand on a set bit.
    always_comb begin
        add_x   = (r_op == skf_pkg::MDU_DIV && r_first) ? r_acc : {r_acc[WP-2:0], 1'b0};
        add_cin = (r_op == skf_pkg::MDU_DIV);
        if (r_op == skf_pkg::MDU_DIV) begin
            add_y = ~WP'(r_a);
        end else if (r_b[skf_pkg::GAIN_W-1]) begin
            add_y = WP'(r_a);
        end else begin
            add_y = '0;
        end
        add_sum = {1'b0, add_x} + {1'b0, add_y} + (WP+1)'(add_cin);
        ge      = add_sum[WP];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_cnt <= CNT_W'(skf_pkg::GAIN_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_op    <= i_req.op;
            r_a     <= i_a;
            r_first <= 1'b1;
            if (i_req.op == skf_pkg::MDU_DIV) begin
                r_acc <= WP'(i_n);
                r_b   <= '0;
            end else begin
                r_acc <= '0;
                r_b   <= i_b;
            end
        end else if (r_cnt != '0) begin
            r_first <= 1'b0;
            if (r_op == skf_pkg::MDU_DIV) begin
                r_acc <= ge ? add_sum[WP-1:0] : add_x;
                r_b   <= {r_b[skf_pkg::GAIN_W-2:0], ge};
            end else begin
                r_acc <= add_sum[WP-1:0];
                r_b   <= {r_b[skf_pkg::GAIN_W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_acc      = r_acc;
    assign o_quot     = r_b;

endmodule

`default_nettype wire

// ===== rtl/scalar_kalman_rpy_smoother_top.sv =====
`default_nettype none

// Channel   Dir  Handshake                     Word
// s_axis    in   i_s_axis_tvalid/o_..._tready  roll_in, pitch_in, yaw_in (16 b each)
// m_axis    out  o_m_axis_tvalid/i_..._tready  angles (16 b each), then rates (17 b each)
// cfg       in   i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
// Filtering: each axis makes up to four passes (divide, step, keep, noise) through the
// single shift-add unit; the divide pass is skipped when the error sum is zero.
// Pass-through makes no pass. A new word is taken only while the sequencer idles.
// A finished word waits in the output register; the next input may be taken meanwhile.
// Reset (synchronous, active low) clears estimates to 0 and errors to 1.0.
module scalar_kalman_rpy_smoother_top #(
    parameter int AXES          = skf_pkg::AXES_DEF,
    parameter int EST_FRAC_BITS = skf_pkg::EST_FRAC_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_s_axis_tvalid,
    output logic                                        o_s_axis_tready,
    // roll_in, pitch_in, yaw_in, 16 bits each from bit 0
    input  wire logic [AXES*skf_pkg::ANGLE_W-1:0]       i_s_axis_tdata,
    output logic                                        o_m_axis_tvalid,
    input  wire logic                                   i_m_axis_tready,
    // roll_out, pitch_out, yaw_out (16 b), roll_rate, pitch_rate, yaw_rate (17 b), zero pad
    output logic [((AXES*(skf_pkg::ANGLE_W+skf_pkg::RATE_W)+7)/8)*8-1:0] o_m_axis_tdata,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [skf_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [skf_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int F       = EST_FRAC_BITS;
    localparam int AW      = skf_pkg::ANGLE_W;
    localparam int RW      = skf_pkg::RATE_W;
    localparam int EW      = skf_pkg::ERR_W;
    localparam int GW      = skf_pkg::GAIN_W;
    localparam int GF      = skf_pkg::GAIN_FRAC;
    localparam int WT      = AW + F;
    localparam int WA      = ((WT > 32) ? WT : 32) + 1;
    localparam int WP      = WA + GW;
    localparam int WSM     = WP - GF + 1;
    localparam int WE      = ((WSM > 32) ? WSM : 32) + 2;
    localparam int KEEP_W  = EW + 1;
    localparam int AX_W    = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int OUT_RAW = AXES * (AW + RW);
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_STEP,
        S_UPD,
        S_KEEP,
        S_NOISE,
        S_FIN,
        S_PUSH
    } t_state;

    t_state                        r_state;
    logic [AX_W-1:0]               r_ax;
    logic                          r_ovalid;
    logic [EW-1:0]                 r_meas;
    logic [skf_pkg::NOISE_W-1:0]   r_noise;
    logic                          r_enable;
    logic signed [31:0]            r_est [AXES];
    logic [EW-1:0]                 r_err [AXES];

    logic signed [AW-1:0]          r_smp [AXES];
    logic signed [AW-1:0]          r_prev;
    logic signed [AW-1:0]          r_newout;
    logic signed [31:0]            r_newest;
    logic [WA-1:0]                 r_dmag;
    logic                          r_dneg;
    logic [GW-1:0]                 r_gain;
    logic [WSM-1:0]                r_stepmag;
    logic [KEEP_W-1:0]             r_keep;
    logic [AW-1:0]                 r_ang [AXES];
    logic [RW-1:0]                 r_rate [AXES];
    logic [OUT_RAW-1:0]            r_otdata;

    logic                          r_go;
    skf_pkg::t_mdu_op              r_op;
    logic [WA-1:0]                 r_ma;
    logic [GW-1:0]                 r_mb;
    logic [EW-1:0]                 r_mn;

    skf_pkg::t_mdu_req             mdu_req;
    skf_pkg::t_mdu_rsp             mdu_rsp;
    logic [WP-1:0]                 mdu_p;
    logic [GW-1:0]                 mdu_q;

    logic signed [AW-1:0]          smp;
    logic signed [31:0]            old;
    logic [EW-1:0]                 err;
    logic signed [WT-1:0]          target;
    logic signed [WA-1:0]          delta;
    logic [WA-1:0]                 dmag;
    logic [EW:0]                   den;
    logic                          den_zero;
    logic signed [AW-1:0]          prev_out;
    logic signed [31:0]            pass_est;
    logic [WP:0]                   step_sum;
    logic signed [WE-1:0]          est_sum;
    logic signed [31:0]            upd_est;
    logic [WP:0]                   keep_sum;
    logic signed [32:0]            chg;
    logic [32:0]                   mag;
    logic [WP:0]                   noise_sum;
    logic [WP:0]                   noise_val;
    logic [WP+1:0]                 err_sum;
    logic [EW-1:0]                 err_new;
    logic signed [RW-1:0]          rate_val;
    logic [OUT_RAW-1:0]            pack;
    logic                          in_take;
    logic                          out_load;

    function automatic logic signed [AW-1:0] round_out(input logic signed [31:0] est);
        logic signed [32:0]   s;
        logic signed [32:0]   q;
        logic signed [AW-1:0] r;
        s = 33'(est) + (33'sd1 <<< (F - 1));
        q = s >>> F;
        if (q > 33'sd32767) begin
            r = 16'sh7FFF;
        end else if (q < -33'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = q[AW-1:0];
        end
        return r;
    endfunction

    skf_mdu #(
        .WA (WA)
    ) u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mdu_req),
        .i_a     (r_ma),
        .i_b     (r_mb),
        .i_n     (r_mn),
        .o_rsp   (mdu_rsp),
        .o_acc   (mdu_p),
        .o_quot  (mdu_q)
    );

    assign mdu_req.go = r_go;
    assign mdu_req.op = r_op;

    always_comb begin
        smp      = r_smp[r_ax];
        old      = r_est[r_ax];
        err      = r_err[r_ax];
        target   = {smp, {F{1'b0}}};
        delta    = WA'(target) - WA'(old);
        dmag     = delta[WA-1] ? WA'(-delta) : WA'(delta);
        den      = {1'b0, err} + {1'b0, r_meas};
        den_zero = (den == '0);
        prev_out = round_out(old);
        pass_est = skf_pkg::clamp32(64'(target));

        // Round the step to nearest, halves up, on the sign-magnitude product.
        step_sum = {1'b0, mdu_p} + (r_dneg ? (WP+1)'(32767) : (WP+1)'(32768));
        est_sum  = r_dneg ? (WE'(old) - WE'(r_stepmag)) : (WE'(old) + WE'(r_stepmag));
        upd_est  = skf_pkg::clamp32(64'(est_sum));

        keep_sum = {1'b0, mdu_p} + (WP+1)'(32768);
        chg      = 33'(r_newest) - 33'(old);
        mag      = chg[32] ? 33'(-chg) : 33'(chg);

        noise_sum = {1'b0, mdu_p} + ((WP+1)'(1) << (F - 1));
        noise_val = noise_sum >> F;
        err_sum   = (WP+2)'(noise_val) + (WP+2)'(r_keep);
        err_new   = (|err_sum[WP+1:EW]) ? '1 : err_sum[EW-1:0];

        rate_val = RW'(r_newout) - RW'(r_prev);

        pack = '0;
        for (int i = 0; i < AXES; i++) begin
            pack[i*AW +: AW]             = r_ang[i];
            pack[AXES*AW + i*RW +: RW]   = r_rate[i];
        end
    end

    assign in_take  = (r_state == S_IDLE) && i_s_axis_tvalid;
    assign out_load = (r_state == S_PUSH) && (!r_ovalid || i_m_axis_tready);

    // Sequencer, state and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ax     <= '0;
            r_ovalid <= 1'b0;
            r_go     <= 1'b0;
            r_meas   <= skf_pkg::MEAS_ERR_RST;
            r_noise  <= skf_pkg::NOISE_RST;
            r_enable <= skf_pkg::ENABLE_RST;
            for (int i = 0; i < AXES; i++) begin
                r_est[i] <= '0;
                r_err[i] <= skf_pkg::MEAS_ERR_RST;
            end
        end else begin
            r_go <= 1'b0;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    skf_pkg::CFG_MEAS_ERR: r_meas   <= i_cfg_data;
                    skf_pkg::CFG_NOISE:    r_noise  <= i_cfg_data[skf_pkg::NOISE_W-1:0];
                    skf_pkg::CFG_ENABLE:   r_enable <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_ax    <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (!r_enable) begin
                        r_state <= S_FIN;
                    end else begin
                        r_go    <= 1'b1;
                        r_state <= den_zero ? S_STEP : S_DIV;
                    end
                end
                S_DIV: begin
                    if (mdu_rsp.done) begin
                        r_go    <= 1'b1;
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (mdu_rsp.done) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_go    <= 1'b1;
                    r_state <= S_KEEP;
                end
                S_KEEP: begin
                    if (mdu_rsp.done) begin
                        r_go    <= 1'b1;
                        r_state <= S_NOISE;
                    end
                end
                S_NOISE: begin
                    if (mdu_rsp.done) begin
                        r_err[r_ax] <= err_new;
                        r_state     <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_est[r_ax] <= r_newest;
                    if (r_ax == AX_W'(AXES - 1)) begin
                        r_state <= S_PUSH;
                    end else begin
                        r_ax    <= r_ax + 1'b1;
                        r_state <= S_LOAD;
                    end
                end
                S_PUSH: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath holding registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            for (int i = 0; i < AXES; i++) begin
                r_smp[i] <= i_s_axis_tdata[i*AW +: AW];
            end
        end

        unique case (r_state)
            S_LOAD: begin
                r_prev   <= prev_out;
                r_dmag   <= dmag;
                r_dneg   <= delta[WA-1];
                r_newest <= pass_est;
                r_newout <= smp;
                r_gain   <= '0;
                r_mn     <= err;
                r_mb     <= '0;
                if (den_zero) begin
                    r_op <= skf_pkg::MDU_MUL;
                    r_ma <= dmag;
                end else begin
                    r_op <= skf_pkg::MDU_DIV;
                    r_ma <= WA'(den);
                end
            end
            S_DIV: begin
                if (mdu_rsp.done) begin
                    r_gain <= mdu_q;
                    r_op   <= skf_pkg::MDU_MUL;
                    r_ma   <= r_dmag;
                    r_mb   <= mdu_q;
                end
            end
            S_STEP: begin
                if (mdu_rsp.done) begin
                    r_stepmag <= step_sum[WP:GF];
                end
            end
            S_UPD: begin
                r_newest <= upd_est;
                r_op     <= skf_pkg::MDU_MUL;
                r_ma     <= WA'(err);
                r_mb     <= skf_pkg::GAIN_ONE - r_gain;
            end
            S_KEEP: begin
                if (mdu_rsp.done) begin
                    r_keep <= keep_sum[GF +: KEEP_W];
                    r_op   <= skf_pkg::MDU_MUL;
                    r_ma   <= WA'(mag);
                    r_mb   <= GW'(r_noise);
                end
            end
            S_NOISE: begin
                if (mdu_rsp.done) begin
                    r_newout <= round_out(r_newest);
                end
            end
            S_FIN: begin
                r_ang[r_ax]  <= r_newout;
                r_rate[r_ax] <= rate_val;
            end
            default: ;
        endcase

        if (out_load) begin
            r_otdata <= pack;
        end
    end

    always_comb begin
        o_m_axis_tdata              = '0;
        o_m_axis_tdata[OUT_RAW-1:0] = r_otdata;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_cfg_ready     = 1'b1;

endmodule

`default_nettype wire

// ===== rtl/skf_chk.sv =====
`default_nettype none

module skf_chk #(
    parameter int AXES = skf_pkg::AXES_DEF
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_s_axis_tvalid,
    input wire logic o_s_axis_tready,
    input wire logic o_m_axis_tvalid,
    input wire logic i_m_axis_tready,
    input wire logic [((AXES*(skf_pkg::ANGLE_W+skf_pkg::RATE_W)+7)/8)*8-1:0] o_m_axis_tdata
);

    // An accepted word keeps the input closed for at least the next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input still open after a word was taken");

    // A result appears only as the sequencer returns to idle
    a_result_at_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> (o_s_axis_tready && !$past(o_s_axis_tready)))
        else $error("result appeared outside the end of a run");

    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
        else $error("output word changed while stalled");

endmodule

bind scalar_kalman_rpy_smoother_top skf_chk #(
    .AXES (AXES)
) u_skf_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
